// ===== sv/pai_pkg.sv =====
`timescale 1ns / 1ps

package pai_pkg;

   // Sizing
   localparam int CAPACITY_DEFAULT = 64;
   localparam int VAL_W            = 32;
   localparam int BOUND_W          = VAL_W + 2;
   localparam int TOL_W            = 31;
   localparam int READ_IDX_W       = 6;
   localparam int COUNT_OUT_W      = 7;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   // Register map (word index taken from paddr above the byte bits)
   localparam logic [0:0] REG_TOLERANCE = 1'b0;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

   // Operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED   = 3'd0,
      ST_REJECTED   = 3'd1,
      ST_DROPPED    = 3'd2,
      ST_READ_OK    = 3'd3,
      ST_READ_EMPTY = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] ret;
      logic signed [VAL_W-1:0] risk;
   } entry_type;

   // New point and its tolerance window on both objectives
   typedef struct packed {
      entry_type                 point;
      logic signed [BOUND_W-1:0] ret_hi;
      logic signed [BOUND_W-1:0] ret_lo;
      logic signed [BOUND_W-1:0] risk_hi;
      logic signed [BOUND_W-1:0] risk_lo;
   } probe_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic cmp;
      logic clear;
      logic compact;
      logic append;
      logic rotate;
   } cell_cmd_type;

   // What a cell shows its neighbors: entry and kill go left, hole and reject go right
   typedef struct packed {
      entry_type ent;
      logic      kill;
      logic      hole;
      logic      rej;
   } link_type;

endpackage

// ===== sv/pai_req_if.sv =====
`timescale 1ns / 1ps

interface pai_req_if import pai_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic signed [VAL_W-1:0] point_return;
   logic signed [VAL_W-1:0] point_risk;
   logic [READ_IDX_W-1:0]   read_index;

   modport source (output valid, func, point_return, point_risk, read_index, input ready);
   modport sink (input valid, func, point_return, point_risk, read_index, output ready);
endinterface

// ===== sv/pai_rsp_if.sv =====
`timescale 1ns / 1ps

interface pai_rsp_if import pai_pkg::*; ();
   logic                    valid;
   logic                    ready;
   status_type              status;
   logic [COUNT_OUT_W-1:0]  removed_count;
   logic [COUNT_OUT_W-1:0]  entry_count;
   logic signed [VAL_W-1:0] entry_return;
   logic signed [VAL_W-1:0] entry_risk;

   modport source (output valid, status, removed_count, entry_count, entry_return, entry_risk,
                   input ready);
   modport sink (input valid, status, removed_count, entry_count, entry_return, entry_risk,
                 output ready);
endinterface

// ===== sv/pai_cell.sv =====
`timescale 1ns / 1ps

module pai_cell import pai_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  probe_type    probe,
   input  logic         live,
   input  logic         is_top,
   input  logic         is_load,
   input  entry_type    wrap_ent,
   input  link_type     left_link,
   input  link_type     right_link,
   output link_type     link
);

   entry_type ent_ff, ent_in;
   logic      kill_ff, kill_in;
   logic      rej_ff, rej_in;

   logic signed [BOUND_W-1:0] ret_x, risk_x;
   logic eq_r, eq_k;
   logic s_gt_r, s_lt_k, p_gt_r, p_lt_k;
   logic new_dom, old_dom, dup;
   logic shift;

   // Tolerance windows: |x - y| < tol  <=>  y - tol < x < y + tol
   assign ret_x  = $signed({{2{ent_ff.ret[VAL_W-1]}}, ent_ff.ret});
   assign risk_x = $signed({{2{ent_ff.risk[VAL_W-1]}}, ent_ff.risk});
   assign eq_r   = (ret_x < probe.ret_hi) && (ret_x > probe.ret_lo);
   assign eq_k   = (risk_x < probe.risk_hi) && (risk_x > probe.risk_lo);

   assign s_gt_r = ent_ff.ret > probe.point.ret;
   assign s_lt_k = ent_ff.risk < probe.point.risk;
   assign p_gt_r = probe.point.ret > ent_ff.ret;
   assign p_lt_k = probe.point.risk < ent_ff.risk;

   // Domination in both directions, plus near-duplicate
   assign new_dom = (p_gt_r && !eq_r && (p_lt_k || eq_k)) ||
                    (p_lt_k && !eq_k && (p_gt_r || eq_r));
   assign old_dom = (s_gt_r && !eq_r && (s_lt_k || eq_k)) ||
                    (s_lt_k && !eq_k && (s_gt_r || eq_r));
   assign dup     = eq_r && eq_k;

   // Shift when a killed live entry sits here or anywhere to the left
   assign shift = left_link.hole || (live && kill_ff);

   assign link.ent  = ent_ff;
   assign link.kill = kill_ff;
   assign link.hole = shift;
   assign link.rej  = left_link.rej || rej_ff;

   always_comb begin
      ent_in  = ent_ff;
      kill_in = kill_ff;
      rej_in  = rej_ff;
      if (cmd.clear) begin
         kill_in = 1'b0;
         rej_in  = 1'b0;
      end
      if (cmd.cmp) begin
         kill_in = live && new_dom;
         rej_in  = live && (old_dom || dup);
      end
      // Close one hole: pull the right neighbor in
      if (cmd.compact && shift) begin
         ent_in  = right_link.ent;
         kill_in = right_link.kill;
      end
      if (cmd.append && is_load) begin
         ent_in = probe.point;
      end
      // Rotate the live region left by one
      if (cmd.rotate) begin
         if (is_top) begin
            ent_in = wrap_ent;
         end else if (live) begin
            ent_in = right_link.ent;
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         kill_ff <= 1'b0;
         rej_ff  <= 1'b0;
      end else begin
         kill_ff <= kill_in;
         rej_ff  <= rej_in;
      end
   end

endmodule

// ===== sv/pai_csr.sv =====
`timescale 1ns / 1ps

module pai_csr import pai_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [TOL_W-1:0]      tolerance
);

   logic [TOL_W-1:0] tol_ff, tol_in;
   logic             tol_sel;

   assign tol_sel    = (csr_paddr[CSR_ADDR_W-1:2] == REG_TOLERANCE);
   assign csr_pready = 1'b1;
   assign tolerance  = tol_ff;

   // Take the write in the access phase
   always_comb begin
      tol_in = tol_ff;
      if (csr_psel && csr_penable && csr_pwrite && tol_sel) begin
         tol_in = csr_pwdata[TOL_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (tol_sel) begin
         csr_prdata = CSR_DATA_W'(tol_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

endmodule

// ===== sv/pareto_archive_insert_top.sv =====
`timescale 1ns / 1ps

// Bounded two-objective Pareto archive held in a row of CAPACITY cells, one
// entry per cell in insertion order. Each cell compares its entry with a new
// point in the same cycle; compaction then closes one removed entry per cycle
// by shifting the tail of the row one cell left, and reads rotate the live
// entries once around the row, capturing the requested one as it passes the
// head cell. An insert word that is kept or dropped goes through compare,
// decide, one shift for each entry it removes, append or drop, and result; a
// rejected insert goes through compare, decide and result. A read word
// rotates once for each stored entry and then gives its result, or goes
// straight to the result when the index is at or beyond the stored count. A
// result that finds the output register still full waits until the receiver
// takes the word held there. One word is worked on at a time; a new word is
// taken while the previous result still waits in the output register.
// Tolerance is written through the APB port at byte address 0 and must only
// be changed while the block is idle.

module pareto_archive_insert_top import pai_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   pai_req_if.sink               req_ch,
   pai_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > READ_IDX_W) ? CNT_W : READ_IDX_W;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_CMP     = 6'b000010,
      S_DECIDE  = 6'b000100,
      S_COMPACT = 6'b001000,
      S_ROTATE  = 6'b010000,
      S_FINISH  = 6'b100000
   } state_type;

   logic [TOL_W-1:0] tolerance;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      removed_ff, removed_in;
   logic [IDX_W-1:0]      step_ff, step_in;
   logic [READ_IDX_W-1:0] idx_ff, idx_in;
   status_type            status_ff, status_in;
   entry_type             rd_ff, rd_in;
   probe_type             probe_ff, probe_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0]  rsp_removed_ff, rsp_removed_in;
   logic [COUNT_OUT_W-1:0]  rsp_count_ff, rsp_count_in;
   entry_type               rsp_ent_ff, rsp_ent_in;

   cell_cmd_type cmd;
   link_type     links [CAPACITY];
   logic         hole_any, rej_any;
   entry_type    head_ent;

   pai_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .tolerance   (tolerance)
   );

   // Row of cells, linked to both neighbors
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      link_type left_l, right_l;
      logic     live, is_top, is_load;

      if (g == 0) begin : g_head
         assign left_l = '0;
      end else begin : g_mid
         assign left_l = links[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_l = '0;
      end else begin : g_body
         assign right_l = links[g+1];
      end

      assign live    = cnt_ff > CNT_W'(g);
      assign is_top  = cnt_ff == CNT_W'(g + 1);
      assign is_load = cnt_ff == CNT_W'(g);

      pai_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .probe      (probe_ff),
         .live       (live),
         .is_top     (is_top),
         .is_load    (is_load),
         .wrap_ent   (head_ent),
         .left_link  (left_l),
         .right_link (right_l),
         .link       (links[g])
      );
   end

   assign hole_any = links[CAPACITY-1].hole;
   assign rej_any  = links[CAPACITY-1].rej;
   assign head_ent = links[0].ent;

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.removed_count = rsp_removed_ff;
   assign rsp_ch.entry_count   = rsp_count_ff;
   assign rsp_ch.entry_return  = rsp_ent_ff.ret;
   assign rsp_ch.entry_risk    = rsp_ent_ff.risk;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      removed_in = removed_ff;
      step_in    = step_ff;
      idx_in     = idx_ff;
      status_in  = status_ff;
      rd_in      = rd_ff;
      probe_in   = probe_ff;
      cmd        = '0;

      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_ent_in     = rsp_ent_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               idx_in               = req_ch.read_index;
               probe_in.point.ret   = req_ch.point_return;
               probe_in.point.risk  = req_ch.point_risk;
               probe_in.ret_hi  = $signed({{2{req_ch.point_return[VAL_W-1]}},
                                           req_ch.point_return}) +
                                  $signed({3'b000, tolerance});
               probe_in.ret_lo  = $signed({{2{req_ch.point_return[VAL_W-1]}},
                                           req_ch.point_return}) -
                                  $signed({3'b000, tolerance});
               probe_in.risk_hi = $signed({{2{req_ch.point_risk[VAL_W-1]}},
                                           req_ch.point_risk}) +
                                  $signed({3'b000, tolerance});
               probe_in.risk_lo = $signed({{2{req_ch.point_risk[VAL_W-1]}},
                                           req_ch.point_risk}) -
                                  $signed({3'b000, tolerance});
               removed_in = '0;
               rd_in      = '0;
               step_in    = '0;
               if (req_ch.func == FUNC_READ) begin
                  if (CMP_W'(req_ch.read_index) < CMP_W'(cnt_ff)) begin
                     state_in = S_ROTATE;
                  end else begin
                     status_in = ST_READ_EMPTY;
                     state_in  = S_FINISH;
                  end
               end else begin
                  state_in = S_CMP;
               end
            end
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (rej_any) begin
               cmd.clear = 1'b1;
               status_in = ST_REJECTED;
               state_in  = S_FINISH;
            end else begin
               state_in = S_COMPACT;
            end
         end
         S_COMPACT: begin
            // Close one hole a cycle, then append or drop
            if (hole_any) begin
               cmd.compact = 1'b1;
               cnt_in      = cnt_ff - CNT_W'(1);
               removed_in  = removed_ff + CNT_W'(1);
            end else if (cnt_ff >= CNT_W'(CAPACITY)) begin
               status_in = ST_DROPPED;
               state_in  = S_FINISH;
            end else begin
               cmd.append = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
               status_in  = ST_INSERTED;
               state_in   = S_FINISH;
            end
         end
         S_ROTATE: begin
            cmd.rotate = 1'b1;
            if (CMP_W'(step_ff) == CMP_W'(idx_ff)) begin
               rd_in = head_ent;
            end
            step_in = step_ff + IDX_W'(1);
            if (CNT_W'(step_ff) == cnt_ff - CNT_W'(1)) begin
               status_in = ST_READ_OK;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_removed_in = COUNT_OUT_W'(removed_ff);
               rsp_count_in   = COUNT_OUT_W'(cnt_ff);
               rsp_ent_in     = rd_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      removed_ff     <= removed_in;
      step_ff        <= step_in;
      idx_ff         <= idx_in;
      status_ff      <= status_in;
      rd_ff          <= rd_in;
      probe_ff       <= probe_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_ent_ff     <= rsp_ent_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("archive count above capacity");

   a_shift_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMPACT && hole_any) |=> (cnt_ff == $past(cnt_ff) - CNT_W'(1)))
      else $error("compaction step did not drop one entry");

   a_rotate_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROTATE) |-> (CNT_W'(step_ff) < cnt_ff))
      else $error("rotation ran past the live entries");

   a_finish_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == S_FINISH))
      else $error("result overwrote a pending word");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && rej_any) |=> (removed_ff == '0 && cnt_ff == $past(cnt_ff)))
      else $error("rejected insert changed the archive");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import pai_pkg::*;

   localparam int ARCH_DEPTH = CAPACITY_DEFAULT;
   localparam int IDLE_LIMIT = 3000;
   localparam logic [CSR_ADDR_W-1:0] TOL_ADDR = {REG_TOLERANCE, 2'b00};
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef struct {
      status_type              status;
      logic [COUNT_OUT_W-1:0]  removed;
      logic [COUNT_OUT_W-1:0]  count;
      logic signed [VAL_W-1:0] ret;
      logic signed [VAL_W-1:0] risk;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pai_req_if req_ch ();
   pai_rsp_if rsp_ch ();

   pareto_archive_insert_top #(.CAPACITY(ARCH_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predicted archive and tolerance
   logic [TOL_W-1:0]        tol_q;
   logic signed [VAL_W-1:0] arch_ret [ARCH_DEPTH];
   logic signed [VAL_W-1:0] arch_risk [ARCH_DEPTH];
   int                      arch_count;
   outcome_type             pending_outcomes [$];

   int       errors;
   int       burst_left;
   int       stall_left;
   bit [31:0] stall_cycle;
   int       quiet_cycles;
   longint   front_step;
   longint   front_ret0;
   longint   front_risk0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Equal within tolerance, exact in 64 bits
   function automatic bit within_tol(input logic signed [VAL_W-1:0] a, b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) begin
         d = -d;
      end
      return d < longint'(tol_q);
   endfunction

   // True when point a dominates point b (return maximized, risk minimized)
   function automatic bit beats(input logic signed [VAL_W-1:0] ar, ak, br, bk);
      bit eqr, eqk;
      eqr = within_tol(ar, br);
      eqk = within_tol(ak, bk);
      return ((ar > br) && !eqr && ((ak < bk) || eqk)) ||
             ((ak < bk) && !eqk && ((ar > br) || eqr));
   endfunction

   // Apply one word to the predicted archive and return the expected result
   function automatic outcome_type archive_apply(input logic fn,
                                                 input logic signed [VAL_W-1:0] r, k,
                                                 input logic [READ_IDX_W-1:0] idx);
      outcome_type o;
      bit       rej;
      int       w;
      int       gone;
      o.status = ST_INSERTED;
      o.ret    = '0;
      o.risk   = '0;
      rej      = 1'b0;
      w        = 0;
      gone     = 0;
      if (fn == FUNC_READ) begin
         if (int'(idx) < arch_count) begin
            o.status = ST_READ_OK;
            o.ret    = arch_ret[idx];
            o.risk   = arch_risk[idx];
         end else begin
            o.status = ST_READ_EMPTY;
         end
      end else begin
         for (int i = 0; i < arch_count; i++) begin
            if (beats(arch_ret[i], arch_risk[i], r, k) ||
                (within_tol(arch_ret[i], r) && within_tol(arch_risk[i], k))) begin
               rej = 1'b1;
            end
         end
         if (rej) begin
            o.status = ST_REJECTED;
         end else begin
            // drop dominated entries and close the holes in order
            for (int i = 0; i < arch_count; i++) begin
               if (beats(r, k, arch_ret[i], arch_risk[i])) begin
                  gone++;
               end else begin
                  arch_ret[w]  = arch_ret[i];
                  arch_risk[w] = arch_risk[i];
                  w++;
               end
            end
            arch_count = w;
            if (arch_count >= ARCH_DEPTH) begin
               o.status = ST_DROPPED;
            end else begin
               arch_ret[arch_count]  = r;
               arch_risk[arch_count] = k;
               arch_count++;
            end
         end
      end
      o.removed = gone[COUNT_OUT_W-1:0];
      o.count   = arch_count[COUNT_OUT_W-1:0];
      return o;
   endfunction

   function automatic logic signed [VAL_W-1:0] wrap32(input longint v);
      return v[VAL_W-1:0];
   endfunction

   // Uniform offset in [-q, q]
   function automatic longint jitter(input longint q);
      return longint'($urandom_range(0, 32'(2 * q))) - q;
   endfunction

   // Send one word in bursts with random gaps, predict it once accepted
   task automatic send_word(input logic fn, input logic signed [VAL_W-1:0] r, k,
                            input logic [READ_IDX_W-1:0] idx);
      int          gap;
      bit          got;
      outcome_type want;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 9);
         end
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.func         <= fn;
      req_ch.point_return <= r;
      req_ch.point_risk   <= k;
      req_ch.read_index   <= idx;
      do begin
         @(negedge clock);
         got = req_ch.ready;
         @(posedge clock);
      end while (!got);
      want             = archive_apply(fn, r, k, idx);
      pending_outcomes = {pending_outcomes, want};
   endtask

   task automatic put_point(input logic signed [VAL_W-1:0] r, k);
      send_word(FUNC_INSERT, r, k, READ_IDX_W'($urandom));
   endtask

   task automatic read_at(input int idx);
      send_word(FUNC_READ, $urandom, $urandom, READ_IDX_W'(idx));
   endtask

   // Hold the sender until every expected result has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
      burst_left = 0;
   endtask

   // Write the tolerance register, then read it back
   task automatic write_tolerance(input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] got;
      bit                    rdy;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TOL_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = csr_pready;
         @(posedge clock);
      end while (!rdy);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tol_q = value[TOL_W-1:0];
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = csr_pready;
         got = csr_prdata;
         @(posedge clock);
      end while (!rdy);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== CSR_DATA_W'(tol_q)) begin
         errors++;
         $display("%0t: tolerance readback expected %0h got %0h", $time, tol_q, got);
      end
   endtask

   // Quiesce, set the tolerance, and pick a fresh front for random points
   task automatic begin_phase(input logic [CSR_DATA_W-1:0] value);
      drain();
      write_tolerance(value);
      front_step = 3 * longint'(tol_q) + 1 + $urandom_range(0, 63);
      if (front_step > (longint'(1) << 22)) begin
         front_step = longint'(1) << 22;
      end
      front_ret0  = (longint'(1) << 27) + $urandom_range(0, 1 << 26);
      front_risk0 = longint'($urandom_range(0, 1 << 26)) - (longint'(1) << 28);
   endtask

   // One random word, mostly points near the current front
   task automatic random_word();
      int     pick, j, x, span;
      longint q;
      pick = $urandom_range(0, 99);
      q    = front_step / 4;
      x    = $urandom_range(0, 95);
      if (pick < 18) begin
         if (arch_count != 0 && $urandom_range(0, 3) != 0) begin
            read_at($urandom_range(0, arch_count - 1));
         end else begin
            read_at($urandom_range(0, 63));
         end
      end else if (pick < 58 || (pick < 73 && arch_count == 0)) begin
         put_point(wrap32(front_ret0 + x * front_step + jitter(q)),
                   wrap32(front_risk0 + x * front_step + jitter(q)));
      end else if (pick < 73) begin
         // near copy of a stored entry
         j = $urandom_range(0, arch_count - 1);
         put_point(wrap32(arch_ret[j] + jitter(longint'(tol_q))),
                   wrap32(arch_risk[j] + jitter(longint'(tol_q))));
      end else if (pick < 80) begin
         // knee point that wipes a run of the front
         span = $urandom_range(1, 8);
         put_point(wrap32(front_ret0 + (x + span) * front_step),
                   wrap32(front_risk0 + x * front_step));
      end else if (pick < 81) begin
         put_point(wrap32(front_ret0 + 200 * front_step), wrap32(front_risk0 - front_step));
      end else begin
         put_point($urandom, $urandom);
      end
   endtask

   task automatic test_directed_edges();
      read_at(0);
      put_point(0, 0);
      put_point(0, 0);
      put_point(1, 0);
      put_point(VAL_MAX, VAL_MAX);
      put_point(VAL_MIN, VAL_MIN);
      put_point(VAL_MIN, VAL_MAX);
      put_point(2, -1);
      for (int i = 0; i < 4; i++) begin
         read_at(i);
      end
      read_at(63);
   endtask

   // With zero tolerance exact copies are kept, and equal is not "no worse"
   task automatic test_zero_tolerance();
      begin_phase(0);
      put_point(5, 5);
      put_point(5, 5);
      put_point(5, 6);
      read_at(4);
      read_at(5);
   endtask

   // Fill the archive along a front, overflow it, then free room with a knee
   task automatic test_full_archive();
      begin_phase(32'h0001_0000);
      for (int x = 0; x < 80; x++) begin
         put_point(wrap32(front_ret0 + x * front_step), wrap32(front_risk0 + x * front_step));
      end
      put_point(wrap32(front_ret0 + 70 * front_step), wrap32(front_risk0 + 60 * front_step));
      read_at(62);
      read_at(0);
      read_at(63);
      for (int i = 0; i < 60; i++) begin
         random_word();
      end
   endtask

   task automatic test_random_traffic(input logic [CSR_DATA_W-1:0] value, input int n);
      begin_phase(value);
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) begin
            drain();
         end
         random_word();
      end
   endtask

   task automatic test_max_tolerance();
      begin_phase(32'hFFFF_FFFF);
      put_point(VAL_MIN, VAL_MAX);
      put_point(VAL_MAX, VAL_MIN);
      put_point(VAL_MIN, VAL_MIN);
      for (int i = 0; i < 200; i++) begin
         random_word();
      end
   endtask

   // Receiver stalls: none, short and frequent, mixed, rare and long
   always @(posedge clock) begin
      stall_cycle++;
      if (stall_left == 0) begin
         case (stall_cycle[10:9])
            2'd0: begin
               stall_left = 0;
            end
            2'd1: begin
               stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            end
            2'd2: begin
               stall_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : 0;
            end
            default: begin
               stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : 0;
            end
         endcase
      end
      rsp_ch.ready <= (stall_left == 0);
      if (stall_left != 0) begin
         stall_left--;
      end
   end

   task automatic check_field(input string what, input logic [VAL_W-1:0] want, got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      end
   endtask

   // Compare each result word with the oldest prediction
   always @(negedge clock) begin : check_words
      outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            errors++;
            $display("%0t: result word with none expected, status %0d", $time,
                     rsp_ch.status);
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", VAL_W'(want.status), VAL_W'(rsp_ch.status));
            check_field("removed_count", VAL_W'(want.removed), VAL_W'(rsp_ch.removed_count));
            check_field("entry_count", VAL_W'(want.count), VAL_W'(rsp_ch.entry_count));
            check_field("entry_return", want.ret, rsp_ch.entry_return);
            check_field("entry_risk", want.risk, rsp_ch.entry_risk);
         end
      end
   end

   // Stop when no word moves for too long
   always @(negedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      errors              = 0;
      burst_left          = 0;
      stall_left          = 0;
      stall_cycle         = '0;
      quiet_cycles        = 0;
      tol_q               = TOL_RESET;
      arch_count          = 0;
      front_step          = 1;
      front_ret0          = 0;
      front_risk0         = 0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_INSERT;
      req_ch.point_return = '0;
      req_ch.point_risk   = '0;
      req_ch.read_index   = '0;
      rsp_ch.ready        = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_edges();
      test_zero_tolerance();
      test_full_archive();
      test_random_traffic(32'd1, 400);
      test_random_traffic(32'd0, 300);
      test_random_traffic(32'h0001_0000, 420);
      test_random_traffic($urandom_range(2, 32'h0003_FFFF), 350);
      test_max_tolerance();

      drain();
      repeat (80) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pai_pkg.sv
sv/pai_req_if.sv
sv/pai_rsp_if.sv
sv/pai_cell.sv
sv/pai_csr.sv
sv/pareto_archive_insert_top.sv
sim/tb.sv
